FILE: src/kalman_angle_bias_filter_top_assert.svh
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clk_i, held off during reset.
`ifndef KALMAN_ANGLE_BIAS_FILTER_TOP_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_TOP_ASSERT_SVH

// Property that must hold in the same cycle.
`define KABF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KABF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/kabf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types, constants and helpers of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int NUM_AXES_DEF  = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W  = 32;
  localparam int AXIS_W  = 2;
  localparam int DT_W    = 16;
  localparam int NOISE_W = 16;
  localparam int R_W     = 31;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;

  // serial multiplier operands: A up to 36 bits signed, B up to 33 bits signed
  localparam int MA_W   = 36;
  localparam int MB_W   = 33;
  localparam int PROD_W = MA_W + 1 + MB_W;
  localparam int WIDE_W = 72;
  localparam int DP_W   = 34;
  localparam int DEN_W  = 33;

  localparam logic [DT_W-1:0]    DT_RST = 16'd3277;
  localparam logic [NOISE_W-1:0] QA_RST = 16'd197;
  localparam logic [NOISE_W-1:0] QB_RST = 16'd1966;
  localparam logic [R_W-1:0]     R_RST  = 31'd3467;
  localparam logic signed [DATA_W-1:0] COV_RST = 32'sd655;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = WIDE_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME,
    REG_ANGLE_NOISE,
    REG_BIAS_NOISE,
    REG_MEASURE_NOISE
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_PRED_ANGLE,
    OP_DT_P11,
    OP_PRED_P00,
    OP_PRED_P11,
    OP_GAIN_K0,
    OP_GAIN_K1,
    OP_CORR_ANGLE,
    OP_CORR_BIAS,
    OP_CORR_P10,
    OP_CORR_P11,
    OP_CORR_P00,
    OP_CORR_P01
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] gain;
  } div_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[DATA_W-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[DATA_W-1:0];
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

FILE: src/kabf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_mul
// Bit-serial signed multiplier, one bit of B per cycle, with round-half-up
// scaling by 2^-FRAC_BITS.
// ----------------------------------------------------------------------------
module kabf_mul import kabf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [MA_W-1:0] a_i,
  input  logic signed [MB_W-1:0] b_i,
  output mul_rsp_t               rsp_o
);

  localparam int HI_W = MA_W + 1;
  localparam int CNT_W = $clog2(MB_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MB_W - 1);
  localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(MB_W);
  localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

  logic                    busy_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [MA_W-1:0]  a_q;
  logic [MB_W-1:0]         b_q;
  logic signed [HI_W-1:0]  hi_q;
  logic [MB_W-1:0]         lo_q;
  logic signed [WIDE_W-1:0] res_q;

  logic signed [HI_W:0]    addend;
  logic signed [HI_W:0]    sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [WIDE_W-1:0] rnd;

  always_comb begin
    if (!b_q[0]) begin
      addend = '0;
    end else if (cnt_q == LAST) begin
      addend = -((HI_W+1)'(a_q));   // sign bit of B carries negative weight
    end else begin
      addend = (HI_W+1)'(a_q);
    end
    sum  = (HI_W+1)'(hi_q) + addend;
    prod = {hi_q, lo_q};
    rnd  = WIDE_W'(prod) + HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == DONE_CNT) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == DONE_CNT) begin
        res_q <= rnd >>> FRAC_BITS;
      end else begin
        hi_q <= sum[HI_W:1];
        lo_q <= {sum[0], lo_q[MB_W-1:1]};
        b_q  <= {1'b0, b_q[MB_W-1:1]};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: src/kabf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_div
// Restoring divider, one quotient bit per cycle: gain = sat(num*2^F / den),
// truncated toward zero. den is taken as positive.
// ----------------------------------------------------------------------------
module kabf_div import kabf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] num_i,
  input  logic [DEN_W-1:0]         den_i,
  output div_rsp_t                 rsp_o
);

  localparam int QW = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);
  localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(QW);
  localparam logic [QW-1:0] POS_LIM = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIM = QW'(64'h8000_0000);

  logic                busy_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [QW-1:0]       dvd_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DEN_W-1:0]    den_q;
  logic                neg_q;
  logic signed [DATA_W-1:0] gain_q;

  logic [DATA_W-1:0]   mag;
  logic [DEN_W:0]      trial;
  logic                qbit;
  logic [QW-1:0]       qneg;

  always_comb begin
    mag   = num_i[DATA_W-1] ? DATA_W'(-((DATA_W+1)'(num_i))) : DATA_W'(num_i);
    trial = {rem_q, dvd_q[QW-1]};
    qbit  = (trial >= (DEN_W+1)'(den_q));
    qneg  = -dvd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == DONE_CNT) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= QW'(mag) << FRAC_BITS;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[DATA_W-1];
    end else if (busy_q) begin
      if (cnt_q == DONE_CNT) begin
        if (neg_q) begin
          gain_q <= (dvd_q > NEG_LIM) ? SAT_MIN[DATA_W-1:0] : qneg[DATA_W-1:0];
        end else begin
          gain_q <= (dvd_q > POS_LIM) ? SAT_MAX[DATA_W-1:0] : dvd_q[DATA_W-1:0];
        end
      end else begin
        rem_q <= qbit ? DEN_W'(trial - (DEN_W+1)'(den_q)) : trial[DEN_W-1:0];
        dvd_q <= {dvd_q[QW-2:0], qbit};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.gain = gain_q;

endmodule

FILE: src/kalman_angle_bias_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_top
// Multi-axis two-state (angle, gyro bias) Kalman filter, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each input transaction names an axis and carries a measured angle and a gyro
// rate; one output transaction returns that axis's new angle and bias
// estimates. The block handles one transaction at a time, working it through
// one bit-serial multiplier (ten products per step) and one restoring divider
// (two gains per step), then loading the result into the output register. A
// new input is taken as soon as the previous result sits in the output
// register, even if the sink has not taken it yet. An axis at or above
// NUM_AXES leaves all state alone and returns zero estimates. Configuration
// writes land at once and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_top import kabf_pkg::*; #(
  parameter int NUM_AXES  = NUM_AXES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [AXIS_W-1:0]        axis_i,
  input  logic signed [DATA_W-1:0] meas_angle_i,
  input  logic signed [DATA_W-1:0] gyro_rate_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [AXIS_W-1:0]        axis_out_o,
  output logic signed [DATA_W-1:0] angle_est_o,
  output logic signed [DATA_W-1:0] bias_est_o
);

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // configuration registers
  logic [DT_W-1:0]    dt_q;
  logic [NOISE_W-1:0] qa_q, qb_q;
  logic [R_W-1:0]     r_q;

  // per-axis filter state
  logic signed [DATA_W-1:0] ang_mem_q [NUM_AXES];
  logic signed [DATA_W-1:0] bias_mem_q[NUM_AXES];
  logic signed [DATA_W-1:0] p00_mem_q [NUM_AXES];
  logic signed [DATA_W-1:0] p01_mem_q [NUM_AXES];
  logic signed [DATA_W-1:0] p10_mem_q [NUM_AXES];
  logic signed [DATA_W-1:0] p11_mem_q [NUM_AXES];

  // working copy of the active axis
  logic [AXIS_W-1:0]        axis_q;
  logic                     in_range_q;
  logic signed [DATA_W-1:0] meas_q, rate_q;
  logic signed [DATA_W-1:0] a_q, b_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [DATA_W-1:0] k0_q, k1_q, y_q;
  logic signed [DP_W-1:0]   dp_q;     // dt*P11, shared by three updates

  // sequencer
  state_e state_q, state_d;
  op_e    op_q, op_d;

  // output register
  logic                     out_valid_q;
  logic [AXIS_W-1:0]        out_axis_q;
  logic signed [DATA_W-1:0] out_ang_q, out_bias_q;

  // arithmetic units
  logic                     mul_start, div_start;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [DATA_W-1:0] div_num;
  mul_rsp_t                 mul_rsp;
  div_rsp_t                 div_rsp;

  logic                     in_fire, in_ok, is_div, unit_done, last_op, out_load;
  logic [AXW-1:0]           in_idx, cur_idx;
  logic signed [DP_W-1:0]   s_sum;
  logic                     s_pos;
  logic signed [MB_W-1:0]   dt_b;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ok      = (32'(axis_i) < NUM_AXES);
  assign in_idx     = AXW'(axis_i);
  assign cur_idx    = AXW'(axis_q);

  // innovation variance S = P00 + r, positive check gates the gains
  assign s_sum = DP_W'(p00_q) + DP_W'(r_q);
  assign s_pos = !s_sum[DP_W-1] && (s_sum != '0);
  assign dt_b  = MB_W'(dt_q);

  assign is_div    = (op_q == OP_GAIN_K0) || (op_q == OP_GAIN_K1);
  assign unit_done = is_div ? div_rsp.done : mul_rsp.done;
  assign last_op   = (op_q == OP_CORR_P01);
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // operand selection per step
  always_comb begin
    logic signed [DATA_W:0] diff;
    logic signed [MA_W-1:0] inner;
    diff    = (DATA_W+1)'(rate_q) - (DATA_W+1)'(b_q);
    inner   = MA_W'(dp_q) - MA_W'(p01_q) - MA_W'(p10_q) + MA_W'(qa_q);
    mul_a   = '0;
    mul_b   = dt_b;
    div_num = p00_q;
    case (op_q)
      OP_PRED_ANGLE: mul_a = MA_W'(diff);
      OP_DT_P11:     mul_a = MA_W'(p11_q);
      OP_PRED_P00:   mul_a = inner;
      OP_PRED_P11:   mul_a = MA_W'(qb_q);
      OP_GAIN_K0:    div_num = p00_q;
      OP_GAIN_K1:    div_num = p10_q;
      OP_CORR_ANGLE: begin mul_a = MA_W'(y_q);   mul_b = MB_W'(k0_q); end
      OP_CORR_BIAS:  begin mul_a = MA_W'(y_q);   mul_b = MB_W'(k1_q); end
      OP_CORR_P10:   begin mul_a = MA_W'(p00_q); mul_b = MB_W'(k1_q); end
      OP_CORR_P11:   begin mul_a = MA_W'(p01_q); mul_b = MB_W'(k1_q); end
      OP_CORR_P00:   begin mul_a = MA_W'(p00_q); mul_b = MB_W'(k0_q); end
      OP_CORR_P01:   begin mul_a = MA_W'(p01_q); mul_b = MB_W'(k0_q); end
      default:       mul_a = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = OP_PRED_ANGLE;
          state_d = in_ok ? ST_ISSUE : ST_FINISH;
        end
      end
      ST_ISSUE: begin
        mul_start = !is_div;
        div_start = is_div;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (unit_done) begin
          if (last_op) begin
            state_d = ST_FINISH;
          end else begin
            op_d    = op_e'(op_q + 1'b1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_PRED_ANGLE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= DT_RST;
      qa_q <= QA_RST;
      qb_q <= QB_RST;
      r_q  <= R_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_STEP_TIME:     dt_q <= cfg_wdata_i[DT_W-1:0];
        REG_ANGLE_NOISE:   qa_q <= cfg_wdata_i[NOISE_W-1:0];
        REG_BIAS_NOISE:    qb_q <= cfg_wdata_i[NOISE_W-1:0];
        REG_MEASURE_NOISE: r_q  <= cfg_wdata_i[R_W-1:0];
        default:           dt_q <= dt_q;
      endcase
    end
  end

  // per-axis state, written back when the result is handed off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        ang_mem_q[i]  <= '0;
        bias_mem_q[i] <= '0;
        p00_mem_q[i]  <= COV_RST;
        p01_mem_q[i]  <= '0;
        p10_mem_q[i]  <= '0;
        p11_mem_q[i]  <= COV_RST;
      end
    end else if (out_load && in_range_q) begin
      ang_mem_q[cur_idx]  <= a_q;
      bias_mem_q[cur_idx] <= b_q;
      p00_mem_q[cur_idx]  <= p00_q;
      p01_mem_q[cur_idx]  <= p01_q;
      p10_mem_q[cur_idx]  <= p10_q;
      p11_mem_q[cur_idx]  <= p11_q;
    end
  end

  // working registers: load on accept, update as each step completes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      axis_q     <= axis_i;
      in_range_q <= in_ok;
      meas_q     <= meas_angle_i;
      rate_q     <= gyro_rate_i;
      if (in_ok) begin
        a_q   <= ang_mem_q[in_idx];
        b_q   <= bias_mem_q[in_idx];
        p00_q <= p00_mem_q[in_idx];
        p01_q <= p01_mem_q[in_idx];
        p10_q <= p10_mem_q[in_idx];
        p11_q <= p11_mem_q[in_idx];
      end
    end else if (state_q == ST_WAIT && unit_done) begin
      case (op_q)
        OP_PRED_ANGLE: a_q  <= sat32(WIDE_W'(a_q) + mul_rsp.res);
        OP_DT_P11:     dp_q <= DP_W'(mul_rsp.res);
        OP_PRED_P00: begin
          p00_q <= sat32(WIDE_W'(p00_q) + mul_rsp.res);
          p01_q <= sat32(WIDE_W'(p01_q) - WIDE_W'(dp_q));
          p10_q <= sat32(WIDE_W'(p10_q) - WIDE_W'(dp_q));
        end
        OP_PRED_P11: begin
          p11_q <= sat32(WIDE_W'(p11_q) + mul_rsp.res);
          y_q   <= sat32(WIDE_W'(meas_q) - WIDE_W'(a_q));  // predicted angle is final here
        end
        OP_GAIN_K0:    k0_q  <= s_pos ? div_rsp.gain : '0;
        OP_GAIN_K1:    k1_q  <= s_pos ? div_rsp.gain : '0;
        OP_CORR_ANGLE: a_q   <= sat32(WIDE_W'(a_q) + mul_rsp.res);
        OP_CORR_BIAS:  b_q   <= sat32(WIDE_W'(b_q) + mul_rsp.res);
        // P10 and P11 go first: they need the old P00 and P01
        OP_CORR_P10:   p10_q <= sat32(WIDE_W'(p10_q) - mul_rsp.res);
        OP_CORR_P11:   p11_q <= sat32(WIDE_W'(p11_q) - mul_rsp.res);
        OP_CORR_P00:   p00_q <= sat32(WIDE_W'(p00_q) - mul_rsp.res);
        OP_CORR_P01:   p01_q <= sat32(WIDE_W'(p01_q) - mul_rsp.res);
        default:       a_q   <= a_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_axis_q <= axis_q;
      out_ang_q  <= in_range_q ? a_q : '0;
      out_bias_q <= in_range_q ? b_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis_out_o  = out_axis_q;
  assign angle_est_o = out_ang_q;
  assign bias_est_o  = out_bias_q;

  kabf_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rsp_o  (mul_rsp)
  );

  kabf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (s_sum[DEN_W-1:0]),
    .rsp_o  (div_rsp)
  );

endmodule

FILE: src/kabf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_chk
// Port-level checks of the filter top, attached by bind.
// ----------------------------------------------------------------------------
`include "kalman_angle_bias_filter_top_assert.svh"

module kabf_chk import kabf_pkg::*; #(
  parameter int NUM_AXES = NUM_AXES_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [AXIS_W-1:0]        axis_out_o,
  input logic signed [DATA_W-1:0] angle_est_o,
  input logic signed [DATA_W-1:0] bias_est_o
);

  `KABF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, $stable(angle_est_o) && $stable(bias_est_o), "output changed while stalled")
  `KABF_ASSERT(a_bad_axis_zero, !out_valid_o || (32'(axis_out_o) < NUM_AXES) || (angle_est_o == '0 && bias_est_o == '0), "unknown axis gave nonzero estimate")
  `KABF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted a second transaction back to back")
  `KABF_ASSERT(a_result_from_work, !$rose(out_valid_o) || $past(!in_ready_o), "result appeared without a transaction in work")

endmodule

bind kalman_angle_bias_filter_top kabf_chk #(.NUM_AXES(NUM_AXES)) u_kabf_chk (.*);
